// ===== rtl/sha_pkg.sv =====
// SHA-256 hasher package: shared types, constants and a rotate helper.
package sha_pkg;

   typedef logic [31:0] word_type;

   // front to back queue entry
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_entry_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam int         LEN_START = 56;

   function automatic word_type ror32(input word_type x, input int n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== rtl/sha_front.sv =====
// SHA-256 front end: request intake and a two-entry queue toward the core.
module sha_front
   import sha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_has_byte,
   input  logic          req_end_of_message,
   output logic          q_valid,
   output req_entry_type q_entry,
   input  logic          q_pop
);

   req_entry_type entry_ff [2];
   logic          rd_ptr_ff, rd_ptr_in;
   logic          wr_ptr_ff, wr_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;

   // idle items carry no work and are dropped here
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && (req_has_byte || req_end_of_message);
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{req_data_byte, req_has_byte, req_end_of_message};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("bad count");

endmodule

// ===== rtl/sha_core.sv =====
// SHA-256 back end: block buffer, padding sequencer and one round per cycle.
module sha_core
   import sha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  req_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output word_type      rsp_word [8]
);

   localparam logic [2:0] ST_TAKE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   word_type    buf_ff [16];             // 64 bytes, four per word, first byte high
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic        fin_ff, fin_in;          // current compression is the last of a message
   logic        second_ff, second_in;    // pad byte still to be placed
   logic        pad_blk_ff, pad_blk_in;  // current compression came from padding
   logic [5:0]  round_ff, round_in;
   word_type    chain_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_ff [8];

   // buffer write port
   logic        buf_we;
   logic [5:0]  buf_addr;
   logic [7:0]  buf_data;
   logic [63:0] len_bits;

   word_type    w_new, t_a, t_b, w_cur;

   assign len_bits  = {count_ff, 3'b000};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // schedule word for this round, the next schedule word and the round sums t_a, t_b
   always_comb begin
      w_cur = w_ff[0];
      w_new = w_ff[0] + (ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3))
            + w_ff[9] + (ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10));
      t_a = v_ff[7] + (ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25))
          + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[round_ff] + w_cur;
      t_b = (ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22))
          + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      fin_in       = fin_ff;
      second_in    = second_ff;
      pad_blk_in   = pad_blk_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      buf_we       = 1'b0;
      buf_addr     = fill_ff;
      buf_data     = q_entry.data_byte;
      case (state_ff)
         ST_TAKE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.has_byte) begin
                  buf_we   = 1'b1;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (q_entry.has_byte && fill_ff == 6'd63) begin
                  fin_in     = 1'b0;
                  second_in  = q_entry.end_of_message;
                  pad_blk_in = 1'b0;
                  round_in   = '0;
                  state_in   = ST_ROUND;
               end else if (q_entry.end_of_message) begin
                  state_in = ST_PAD;
                  fill_in  = q_entry.has_byte ? fill_ff + 6'd1 : fill_ff;
                  fin_in   = 1'b0;
                  second_in = 1'b1;
               end
            end
         end
         ST_PAD: begin
            // one buffer byte per cycle; second_ff marks the pad byte not yet placed
            buf_we  = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (second_ff) begin
               buf_data  = PAD_BYTE;
               second_in = 1'b0;
            end else if (fill_ff >= 6'(LEN_START) && fin_ff) begin
               buf_data = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
            end else begin
               buf_data = 8'h00;
            end
            // reaching the length field with the pad byte placed closes the message
            if (fill_ff == 6'(LEN_START - 1)) begin
               fin_in = 1'b1;
            end
            if (fill_ff == 6'd63) begin
               round_in   = '0;
               pad_blk_in = 1'b1;
               state_in   = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fin_ff) begin
               state_in = ST_OUT;
            end else if (second_ff || pad_blk_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               fill_in      = '0;
               count_in     = '0;
               fin_in       = 1'b0;
               state_in     = ST_TAKE;
            end
         end
         default: state_in = ST_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TAKE;
         fill_ff      <= '0;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         second_ff    <= 1'b0;
         pad_blk_ff   <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= INIT_H;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         second_ff    <= second_in;
         pad_blk_ff   <= pad_blk_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
         if (state_ff == ST_OUT && state_in == ST_TAKE) begin
            chain_ff <= INIT_H;
         end
      end
   end

   // block buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[buf_addr[5:2]][{~buf_addr[1:0], 3'b000} +: 8] <= buf_data;
      end
   end

   // working variables and schedule window; the last byte bypasses the buffer
   always_ff @(posedge clock) begin
      if (state_in == ST_ROUND && state_ff != ST_ROUND) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
         for (int j = 0; j < 15; j++) w_ff[j] <= buf_ff[j];
         w_ff[15] <= buf_we ? {buf_ff[15][31:8], buf_data} : buf_ff[15];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t_a;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t_a + t_b;
         for (int j = 0; j < 15; j++) w_ff[j] <= w_ff[j+1];
         w_ff[15] <= w_new;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff <= chain_ff;
      end
   end

   a_pop_only_take: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_TAKE) else $error("pop outside intake");
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(round_ff) == 6'd63) else $error("short round run");
   a_out_after_add: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray result");

endmodule

// ===== rtl/sha256_byte_stream_hasher_top.sv =====
// SHA-256 byte-stream hasher top level: front queue and compression back end.
// Usage:
//   The request channel (req_valid / req_stall) takes one message byte per
//   request: req_data_byte is used when req_has_byte is set, and
//   req_end_of_message closes the message after that byte.
//   The response channel (rsp_valid / rsp_stall) returns one digest of eight
//   big-endian words per closed message.
// Sequence:
//   Bytes are taken one per cycle into the 64-byte block buffer while the
//   core is in intake. A full block holds intake for 64 rounds on the single
//   round unit plus the feed-forward add; the load happens with the last byte.
//   Closing a message walks the buffer tail one byte a cycle for padding,
//   then compresses one or two blocks. A two-entry queue sits between intake
//   and core.
// Reset:
//   Synchronous, active high; chaining words return to the initial values and
//   all counts clear.
// Stall:
//   A stalled response holds its words; the core waits with the next digest
//   until the response register is free, and the queue then backs up to
//   req_stall.
module sha256_byte_stream_hasher_top
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word_0,
   output logic [31:0] rsp_digest_word_1,
   output logic [31:0] rsp_digest_word_2,
   output logic [31:0] rsp_digest_word_3,
   output logic [31:0] rsp_digest_word_4,
   output logic [31:0] rsp_digest_word_5,
   output logic [31:0] rsp_digest_word_6,
   output logic [31:0] rsp_digest_word_7
);

   logic          q_valid;
   logic          q_pop;
   req_entry_type q_entry;
   word_type      digest [8];

   sha_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .q_valid            (q_valid),
      .q_entry            (q_entry),
      .q_pop              (q_pop)
   );

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (digest)
   );

   assign rsp_digest_word_0 = digest[0];
   assign rsp_digest_word_1 = digest[1];
   assign rsp_digest_word_2 = digest[2];
   assign rsp_digest_word_3 = digest[3];
   assign rsp_digest_word_4 = digest[4];
   assign rsp_digest_word_5 = digest[5];
   assign rsp_digest_word_6 = digest[6];
   assign rsp_digest_word_7 = digest[7];

endmodule
